FILE: src/cle_pkg.sv
// ----------------------------------------------------------------------------
// Circular list engine package
// Sizes, opcodes and status codes used by the list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int DEPTH  = 16;
	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam int OPC_W = 3;
	localparam int VAL_W = 32;
	localparam int POS_W = 7;
	localparam int ST_W  = 2;

	localparam logic [OPC_W-1:0] OP_INS_HEAD = 3'd0;
	localparam logic [OPC_W-1:0] OP_INS_TAIL = 3'd1;
	localparam logic [OPC_W-1:0] OP_DEL_HEAD = 3'd2;
	localparam logic [OPC_W-1:0] OP_DEL_POS  = 3'd3;
	localparam logic [OPC_W-1:0] OP_LIST     = 3'd4;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

endpackage

FILE: src/cle_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module cle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: src/circular_list_engine_top.sv
// ----------------------------------------------------------------------------
// Circular list engine
// Ordered circular list of signed values held in a value RAM and a link RAM.
//
// A command beat on the cmd channel carries opcode, item_value and position.
// It is taken when cmd_valid is high and cmd_stall is low; cmd_stall stays
// high while a command is being worked on. Result beats leave on the res
// channel from one output register and are taken when res_valid is high
// and res_stall is low.
// Inserts, delete at head and rejected commands pass at most one link
// repair state (S_INS_LINK or S_DH) before S_EMIT loads their status beat;
// delete at position N walks the link chain in S_DW, one link RAM read per
// cycle, then repairs a link in S_DX. A listing gives one beat per cycle
// unless res_stall holds the output, and the next command is taken once
// its last beat is in the register. Unknown opcodes are taken and give
// no beat. While res_stall is high the output register holds its beat
// and the walk pauses with the RAM read data held.
// Reset empties the list at once; the RAM contents are not cleared, since
// only slots in use are ever read.
// ----------------------------------------------------------------------------
module circular_list_engine_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_stall,
	input  logic [cle_pkg::OPC_W-1:0]        opcode,
	input  logic signed [cle_pkg::VAL_W-1:0] item_value,
	input  logic [cle_pkg::POS_W-1:0]        position,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic signed [cle_pkg::VAL_W-1:0] out_value,
	output logic [cle_pkg::ST_W-1:0]         status,
	output logic [cle_pkg::POS_W-1:0]        entry_count,
	output logic                             last
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_INS_LINK = 3'd1;
	localparam logic [2:0] S_DH       = 3'd2;
	localparam logic [2:0] S_DW       = 3'd3;
	localparam logic [2:0] S_DX       = 3'd4;
	localparam logic [2:0] S_LIST     = 3'd5;
	localparam logic [2:0] S_EMIT     = 3'd6;

	logic [2:0]                    state_q;
	logic [cle_pkg::DEPTH-1:0]     slot_used_q;
	logic [cle_pkg::SLOT_W-1:0]    head_q;
	logic [cle_pkg::SLOT_W-1:0]    tail_q;
	logic [cle_pkg::CNT_W-1:0]     count_q;
	logic [cle_pkg::SLOT_W-1:0]    new_q;
	logic [cle_pkg::SLOT_W-1:0]    tail_old_q;
	logic [cle_pkg::SLOT_W-1:0]    prev_q;
	logic [cle_pkg::SLOT_W-1:0]    del_q;
	logic [cle_pkg::SLOT_W-1:0]    hops_q;
	logic [cle_pkg::CNT_W-1:0]     remain_q;
	logic [cle_pkg::ST_W-1:0]      st_q;
	logic                          res_valid_q;
	logic signed [cle_pkg::VAL_W-1:0] out_value_q;
	logic [cle_pkg::ST_W-1:0]      status_q;
	logic [cle_pkg::POS_W-1:0]     entry_count_q;
	logic                          last_q;

	logic                          cmd_acc;
	logic                          out_free;
	logic                          c_empty;
	logic                          c_full;
	logic                          c_one;
	logic                          pos_ok;
	logic [cle_pkg::SLOT_W-1:0]    free_slot;
	logic [cle_pkg::SLOT_W-1:0]    rd_addr;
	logic                          v_we;
	logic                          v_re;
	logic [cle_pkg::VAL_W-1:0]     value_rdata;
	logic                          l_we;
	logic                          l_re;
	logic [cle_pkg::SLOT_W-1:0]    l_waddr;
	logic [cle_pkg::SLOT_W-1:0]    l_wdata;
	logic [cle_pkg::SLOT_W-1:0]    link_rdata;
	logic                          res_load;
	logic [cle_pkg::VAL_W-1:0]     res_value;
	logic [cle_pkg::ST_W-1:0]      res_status;
	logic                          res_last;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && (state_q == S_IDLE);
	assign out_free  = !res_valid_q || !res_stall;
	assign c_empty   = (count_q == '0);
	assign c_full    = (count_q == cle_pkg::CNT_W'(cle_pkg::DEPTH));
	assign c_one     = (count_q == cle_pkg::CNT_W'(1));
	assign pos_ok    = (position != '0) && (position <= cle_pkg::POS_W'(count_q));
	assign rd_addr   = (state_q == S_IDLE) ? head_q : link_rdata;

	always_comb begin
		free_slot = '0;
		for (int i = cle_pkg::DEPTH - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				free_slot = cle_pkg::SLOT_W'(i);
			end
		end
	end

	always_comb begin
		v_we       = 1'b0;
		v_re       = 1'b0;
		l_we       = 1'b0;
		l_re       = 1'b0;
		l_waddr    = free_slot;
		l_wdata    = head_q;
		res_load   = 1'b0;
		res_value  = '0;
		res_status = cle_pkg::ST_OK;
		res_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					unique case (opcode)
						cle_pkg::OP_INS_HEAD, cle_pkg::OP_INS_TAIL: begin
							if (!c_full) begin
								v_we    = 1'b1;
								l_we    = 1'b1;
								l_waddr = free_slot;
								l_wdata = c_empty ? free_slot : head_q;
							end
						end
						cle_pkg::OP_DEL_HEAD, cle_pkg::OP_DEL_POS: begin
							l_re = !c_empty && !c_one &&
								((opcode == cle_pkg::OP_DEL_HEAD) || pos_ok);
						end
						cle_pkg::OP_LIST: begin
							v_re = !c_empty;
							l_re = !c_empty;
						end
						default: begin
						end
					endcase
				end
			end
			S_INS_LINK: begin
				l_we    = 1'b1;
				l_waddr = tail_old_q;
				l_wdata = new_q;
			end
			S_DH: begin
				l_we    = 1'b1;
				l_waddr = tail_q;
				l_wdata = link_rdata;
			end
			S_DW: begin
				l_re = 1'b1;
			end
			S_DX: begin
				l_we    = 1'b1;
				l_waddr = prev_q;
				l_wdata = link_rdata;
			end
			S_LIST: begin
				if (out_free) begin
					res_load  = 1'b1;
					res_value = value_rdata;
					res_last  = (remain_q == cle_pkg::CNT_W'(1));
					v_re      = !res_last;
					l_re      = !res_last;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					res_load   = 1'b1;
					res_status = st_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_used_q <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			new_q       <= '0;
			tail_old_q  <= '0;
			prev_q      <= '0;
			del_q       <= '0;
			hops_q      <= '0;
			remain_q    <= '0;
			st_q        <= cle_pkg::ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						unique case (opcode)
							cle_pkg::OP_INS_HEAD, cle_pkg::OP_INS_TAIL: begin
								if (c_full) begin
									st_q    <= cle_pkg::ST_FULL;
									state_q <= S_EMIT;
								end else begin
									slot_used_q[free_slot] <= 1'b1;
									count_q <= count_q + cle_pkg::CNT_W'(1);
									st_q    <= cle_pkg::ST_OK;
									if (c_empty) begin
										head_q  <= free_slot;
										tail_q  <= free_slot;
										state_q <= S_EMIT;
									end else begin
										new_q      <= free_slot;
										tail_old_q <= tail_q;
										if (opcode == cle_pkg::OP_INS_HEAD) begin
											head_q <= free_slot;
										end else begin
											tail_q <= free_slot;
										end
										state_q <= S_INS_LINK;
									end
								end
							end
							cle_pkg::OP_DEL_HEAD, cle_pkg::OP_DEL_POS: begin
								priority if (c_empty) begin
									st_q    <= cle_pkg::ST_EMPTY;
									state_q <= S_EMIT;
								end else if ((opcode == cle_pkg::OP_DEL_POS) && !pos_ok) begin
									st_q    <= cle_pkg::ST_BADPOS;
									state_q <= S_EMIT;
								end else if ((opcode == cle_pkg::OP_DEL_HEAD) ||
									(position == cle_pkg::POS_W'(1))) begin
									if (c_one) begin
										slot_used_q[head_q] <= 1'b0;
										head_q  <= '0;
										tail_q  <= '0;
										count_q <= '0;
										st_q    <= cle_pkg::ST_OK;
										state_q <= S_EMIT;
									end else begin
										state_q <= S_DH;
									end
								end else begin
									prev_q  <= head_q;
									hops_q  <= cle_pkg::SLOT_W'(position - cle_pkg::POS_W'(2));
									state_q <= S_DW;
								end
							end
							cle_pkg::OP_LIST: begin
								if (c_empty) begin
									st_q    <= cle_pkg::ST_EMPTY;
									state_q <= S_EMIT;
								end else begin
									remain_q <= count_q;
									state_q  <= S_LIST;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INS_LINK: begin
					st_q    <= cle_pkg::ST_OK;
					state_q <= S_EMIT;
				end
				S_DH: begin
					slot_used_q[head_q] <= 1'b0;
					head_q  <= link_rdata;
					count_q <= count_q - cle_pkg::CNT_W'(1);
					st_q    <= cle_pkg::ST_OK;
					state_q <= S_EMIT;
				end
				S_DW: begin
					if (hops_q != '0) begin
						prev_q <= link_rdata;
						hops_q <= hops_q - cle_pkg::SLOT_W'(1);
					end else begin
						del_q   <= link_rdata;
						state_q <= S_DX;
					end
				end
				S_DX: begin
					if (del_q == tail_q) begin
						tail_q <= prev_q;
					end
					slot_used_q[del_q] <= 1'b0;
					count_q <= count_q - cle_pkg::CNT_W'(1);
					st_q    <= cle_pkg::ST_OK;
					state_q <= S_EMIT;
				end
				S_LIST: begin
					if (out_free) begin
						if (remain_q == cle_pkg::CNT_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							remain_q <= remain_q - cle_pkg::CNT_W'(1);
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_value_q   <= $signed(res_value);
			status_q      <= res_status;
			entry_count_q <= cle_pkg::POS_W'(count_q);
			last_q        <= res_last;
		end
	end

	cle_ram #(
		.WIDTH(cle_pkg::VAL_W),
		.DEPTH(cle_pkg::DEPTH)
	) u_value_ram (
		.clk    (clk),
		.wr_en  (v_we),
		.wr_addr(free_slot),
		.wr_data($unsigned(item_value)),
		.rd_en  (v_re),
		.rd_addr(rd_addr),
		.rd_data(value_rdata)
	);

	cle_ram #(
		.WIDTH(cle_pkg::SLOT_W),
		.DEPTH(cle_pkg::DEPTH)
	) u_link_ram (
		.clk    (clk),
		.wr_en  (l_we),
		.wr_addr(l_waddr),
		.wr_data(l_wdata),
		.rd_en  (l_re),
		.rd_addr(rd_addr),
		.rd_data(link_rdata)
	);

	assign res_valid   = res_valid_q;
	assign out_value   = out_value_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign last        = last_q;

	// The occupancy mask and the count move together.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_used_q) == count_q)
		else $error("slot occupancy and count disagree");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cle_pkg::CNT_W'(cle_pkg::DEPTH))
		else $error("count beyond depth");

	// An empty list has its head and tail slots parked at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		c_empty |-> (head_q == '0) && (tail_q == '0))
		else $error("empty list with stray head or tail");

	// Link repairs only run on lists of two or more entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DH) || (state_q == S_DW) || (state_q == S_DX))
			|-> (count_q >= cle_pkg::CNT_W'(2)))
		else $error("link repair on a short list");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST) |-> (remain_q != '0))
		else $error("listing with no entries left");

	// A stalled beat is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |-> !res_load)
		else $error("result register loaded while stalled");

endmodule
